[hw/rtl/ldf_pkg.sv]
// Package for the length-prefixed frame deframer.
// Holds shared types, constants and the frame-kind classifier.
// No dependencies.
package ldf_pkg;

  localparam int unsigned MaxFrameDefault = 1024;

  localparam logic [7:0]  HeaderFirstReset  = 8'hEB;
  localparam logic [7:0]  HeaderSecondReset = 8'h51;
  localparam logic [10:0] MaxFrameLenReset  = 11'd1024;

  localparam logic [7:0]  KindUpgradeByte = 8'h35;
  localparam logic [7:0]  KindExportByte  = 8'h33;
  localparam logic [16:0] FrameOverhead   = 17'd5;

  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_MAX_FRAME_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_UPGRADE = 2'd1,
    KIND_EXPORT  = 2'd2
  } frame_kind_t;

  typedef enum logic [1:0] {
    ST_HUNT  = 2'd0,
    ST_HEAD1 = 2'd1,
    ST_BODY  = 2'd2
  } sync_state_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [10:0] max_frame_len;
  } ldf_cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic        last;
    logic [1:0]  frame_kind;
    logic        checksum_ok;
    logic        frame_error;
  } ldf_result_t;

  function automatic frame_kind_t classify(input logic [7:0] b);
    frame_kind_t k;
    if (b == KindUpgradeByte) begin
      k = KIND_UPGRADE;
    end else if (b == KindExportByte) begin
      k = KIND_EXPORT;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

[hw/rtl/ldf_cfg_regs.sv]
// Configuration register file of the frame deframer.
// Depends on ldf_pkg for register indexes and reset values.
module ldf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [ldf_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [10:0]                     cfg_data,
  output ldf_pkg::ldf_cfg_t               cfg
);
  import ldf_pkg::*;

  ldf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= HeaderFirstReset;
      cfg_r.header_second <= HeaderSecondReset;
      cfg_r.max_frame_len <= MaxFrameLenReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  cfg_r.header_first  <= cfg_data[7:0];
        CFG_HEADER_SECOND: cfg_r.header_second <= cfg_data[7:0];
        CFG_MAX_FRAME_LEN: cfg_r.max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/ldf_in_reg.sv]
// Input register stage of the frame deframer: holds one received byte.
// Depends on nothing beyond the handshake from the next stage.
module ldf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte_in,
  output logic       in_stall,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  // A new byte can enter whenever the held one moves on or the stage is empty.
  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte_in;
    end
  end

  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

endmodule

[hw/rtl/ldf_parser.sv]
// Frame parser: header hunt, length capture, index count and XOR checksum.
// Updates its state once per byte and forms the result for that byte.
// Depends on ldf_pkg.
module ldf_parser #(
  parameter int unsigned MAX_FRAME = ldf_pkg::MaxFrameDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            byte_q,
  input  ldf_pkg::ldf_cfg_t     cfg,
  output logic                  res_valid,
  output ldf_pkg::ldf_result_t  res
);
  import ldf_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME);
  localparam logic [16:0] MaxFrameW = 17'(MAX_FRAME);

  sync_state_t  state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]  len_r, len_nxt;
  logic [7:0]   xor_r, xor_nxt;
  frame_kind_t  kind_r, kind_nxt;

  logic [15:0]      len_eff;
  logic [CntW+16:0] cnt_wide;
  logic [16:0]      cnt17;
  logic [16:0]      total;
  logic [16:0]      last_idx;
  logic [16:0]      limit;
  logic [16:0]      cfg_max17;
  logic [CntW+9:0]  idx_wide;
  logic             too_long;
  logic             at_end;

  assign cnt_wide  = {17'd0, cnt_r};
  assign cnt17     = cnt_wide[16:0];
  assign idx_wide  = {10'd0, cnt_r};
  assign cfg_max17 = {6'd0, cfg.max_frame_len};
  assign limit     = (MaxFrameW < cfg_max17) ? MaxFrameW : cfg_max17;

  always_comb begin
    if (cnt_r == CntW'(2)) begin
      len_eff = {8'd0, byte_q};
    end else if (cnt_r == CntW'(3)) begin
      len_eff = {byte_q, len_r[7:0]};
    end else begin
      len_eff = len_r;
    end
  end

  assign total    = {1'b0, len_eff} + FrameOverhead;
  assign last_idx = {1'b0, len_eff} + 17'd4;
  assign too_long = (cnt_r == CntW'(3)) && (total > limit);
  assign at_end   = (cnt17 >= 17'd4) && (cnt17 == last_idx);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    kind_nxt  = kind_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (byte_q == cfg.header_first) begin
          state_nxt = ST_HEAD1;
          cnt_nxt   = CntW'(1);
        end
      end
      ST_HEAD1: begin
        if (byte_q == cfg.header_second) begin
          state_nxt = ST_BODY;
          cnt_nxt   = CntW'(2);
          xor_nxt   = byte_q;
        end else begin
          state_nxt = ST_HUNT;
          cnt_nxt   = '0;
          len_nxt   = '0;
          xor_nxt   = '0;
          kind_nxt  = KIND_OTHER;
        end
      end
      ST_BODY: begin
        res_valid      = 1'b1;
        res.data_byte  = byte_q;
        res.byte_index = idx_wide[9:0];
        if (too_long || at_end) begin
          res.last = 1'b1;
          if (too_long) begin
            res.frame_error = 1'b1;
          end else begin
            // The shortest frame carries its kind in the checksum byte itself.
            res.frame_kind  = (cnt_r == CntW'(4)) ? classify(byte_q) : kind_r;
            res.checksum_ok = (xor_r == byte_q);
          end
          state_nxt = ST_HUNT;
          cnt_nxt   = '0;
          len_nxt   = '0;
          xor_nxt   = '0;
          kind_nxt  = KIND_OTHER;
        end else begin
          if (cnt_r == CntW'(4)) begin
            kind_nxt = classify(byte_q);
          end
          len_nxt = len_eff;
          xor_nxt = xor_r ^ byte_q;
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      default: begin
        state_nxt = ST_HUNT;
        cnt_nxt   = '0;
        len_nxt   = '0;
        xor_nxt   = '0;
        kind_nxt  = KIND_OTHER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      cnt_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      kind_r  <= KIND_OTHER;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

[hw/rtl/ldf_out_reg.sv]
// Result register of the frame deframer, driving the output channel.
// Depends on ldf_pkg for the result struct.
module ldf_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  load_valid,
  input  ldf_pkg::ldf_result_t  res,
  input  logic                  out_stall,
  output logic                  free,
  output logic                  out_valid,
  output ldf_pkg::ldf_result_t  out_res
);
  import ldf_pkg::*;

  logic        valid_r, valid_nxt;
  ldf_result_t res_r;

  // The register can take a new result when empty or when its transaction completes now.
  assign free = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = load_valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[hw/rtl/length_prefixed_frame_deframer_top.sv]
// Top level of the length-prefixed frame deframer.
// Instantiates ldf_cfg_regs, ldf_in_reg, ldf_parser and ldf_out_reg; uses ldf_pkg.
//
// The deframer takes one received byte per transaction, hunts for the two
// configured header bytes, reads a little-endian 16-bit length and passes on
// every frame byte from index 2 onward with its index. The final byte carries
// the frame kind and the XOR checksum result; a frame longer than
// min(max_frame_len, MAX_FRAME) ends at its fourth byte with frame_error set.
// Header bytes produce no result. A byte is registered on input, then parsed
// and its result lands in the output register; one byte is accepted every
// cycle while the output is not stalled.
// The configuration port is always ready and should be written while idle.
module length_prefixed_frame_deframer_top #(
  parameter int unsigned MAX_FRAME = ldf_pkg::MaxFrameDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_data_byte,
  output logic [9:0]                     out_byte_index,
  output logic                           out_last,
  output logic [1:0]                     out_frame_kind,
  output logic                           out_checksum_ok,
  output logic                           out_frame_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ldf_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [10:0]                    cfg_data
);
  import ldf_pkg::*;

  ldf_cfg_t    cfg;
  ldf_result_t res;
  ldf_result_t out_res;
  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        free;
  logic        step;
  logic        res_valid;

  assign cfg_ready = 1'b1;
  assign step      = byte_valid && free;

  ldf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ldf_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte_in (in_byte_in),
    .in_stall   (in_stall),
    .advance    (step),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  ldf_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_q    (byte_q),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ldf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .res        (res),
    .out_stall  (out_stall),
    .free       (free),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_data_byte   = out_res.data_byte;
  assign out_byte_index  = out_res.byte_index;
  assign out_last        = out_res.last;
  assign out_frame_kind  = out_res.frame_kind;
  assign out_checksum_ok = out_res.checksum_ok;
  assign out_frame_error = out_res.frame_error;

endmodule

[tb/sv/deframe_checker.sv]
// Checker for the length-prefixed frame deframer: follows the byte, result and
// register channels, predicts every result and compares it field by field.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

module deframe_checker #(
  parameter int unsigned MAX_FRAME = ldf_pkg::MaxFrameDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_byte_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_data_byte,
  input  logic [9:0]                    out_byte_index,
  input  logic                          out_last,
  input  logic [1:0]                    out_frame_kind,
  input  logic                          out_checksum_ok,
  input  logic                          out_frame_error,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ldf_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [10:0]                   cfg_data,
  output int unsigned                   pending_results,
  output int unsigned                   mismatch_count
);
  import ldf_pkg::*;

  // Register copies.
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [10:0] max_len;

  // Parser copy.
  sync_state_t sync_st;
  logic [10:0] byte_cnt;
  logic [15:0] len_field;
  logic [7:0]  run_xor;
  frame_kind_t kind_q;

  ldf_result_t frame_out_q[$];

  function automatic void clear_frame();
    sync_st   = ST_HUNT;
    byte_cnt  = '0;
    len_field = '0;
    run_xor   = '0;
    kind_q    = KIND_OTHER;
  endfunction

  function automatic frame_kind_t kind_from_byte(input logic [7:0] b);
    case (b)
      KindUpgradeByte: kind_from_byte = KIND_UPGRADE;
      KindExportByte:  kind_from_byte = KIND_EXPORT;
      default:         kind_from_byte = KIND_OTHER;
    endcase
  endfunction

  // Advances the parser copy by one byte and returns the result it causes.
  function automatic void deframe_step(input logic [7:0] b, output bit emits,
                                       output ldf_result_t r);
    int unsigned idx;
    int unsigned lim;
    int unsigned total;
    bit ended;
    emits = 1'b0;
    r = '0;
    ended = 1'b0;
    case (sync_st)
      ST_HUNT: begin
        if (b == hdr_first) begin
          sync_st  = ST_HEAD1;
          byte_cnt = 11'd1;
        end
      end
      ST_HEAD1: begin
        // A failed second header byte is not retried as a first header byte.
        if (b == hdr_second) begin
          sync_st  = ST_BODY;
          byte_cnt = 11'd2;
          run_xor  = b;
        end else begin
          clear_frame();
        end
      end
      ST_BODY: begin
        idx = 32'(byte_cnt);
        emits = 1'b1;
        r.data_byte  = b;
        r.byte_index = 10'(idx);
        if (idx == 2) begin
          len_field = {8'h00, b};
        end else if (idx == 3) begin
          len_field[15:8] = b;
          lim = (max_len < MAX_FRAME) ? 32'(max_len) : MAX_FRAME;
          if (len_field + 32'd5 > lim) begin
            r.last        = 1'b1;
            r.frame_error = 1'b1;
            ended = 1'b1;
          end
        end
        total = len_field + 32'd5;
        if (!ended && idx >= 4 && idx + 1 == total) begin
          // With a zero length the kind byte is also the checksum byte.
          r.last        = 1'b1;
          r.frame_kind  = (idx == 4) ? kind_from_byte(b) : kind_q;
          r.checksum_ok = (run_xor == b);
          ended = 1'b1;
        end
        if (ended) begin
          clear_frame();
        end else begin
          if (idx == 4) begin
            kind_q = kind_from_byte(b);
          end
          run_xor  = run_xor ^ b;
          byte_cnt = 11'(idx + 1);
        end
      end
      default: begin
        clear_frame();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] deframer mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [9:0] got_v,
                             input logic [9:0] want_v, input logic [9:0] at_index);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s at byte_index %0d: got %0h, want %0h",
                                name, at_index, got_v, want_v));
    end
  endtask

  always @(posedge clk) begin : watch
    ldf_result_t got;
    ldf_result_t want;
    ldf_result_t predicted;
    bit emits;
    if (!rst_n) begin
      hdr_first  = HeaderFirstReset;
      hdr_second = HeaderSecondReset;
      max_len    = MaxFrameLenReset;
      clear_frame();
      frame_out_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_data_byte, out_byte_index, out_last, out_frame_kind,
               out_checksum_ok, out_frame_error};
        if (frame_out_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending, byte_index %0d",
                                    got.byte_index));
        end else begin
          want = frame_out_q.pop_front();
          check_field("data_byte", 10'(got.data_byte), 10'(want.data_byte),
                      want.byte_index);
          check_field("byte_index", got.byte_index, want.byte_index, want.byte_index);
          check_field("last", 10'(got.last), 10'(want.last), want.byte_index);
          check_field("frame_kind", 10'(got.frame_kind), 10'(want.frame_kind),
                      want.byte_index);
          check_field("checksum_ok", 10'(got.checksum_ok), 10'(want.checksum_ok),
                      want.byte_index);
          check_field("frame_error", 10'(got.frame_error), 10'(want.frame_error),
                      want.byte_index);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER_FIRST:  hdr_first  = cfg_data[7:0];
          CFG_HEADER_SECOND: hdr_second = cfg_data[7:0];
          CFG_MAX_FRAME_LEN: max_len    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        deframe_step(in_byte_in, emits, predicted);
        if (emits) begin
          frame_out_q = {frame_out_q, predicted};
        end
      end
    end
    pending_results <= frame_out_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Top-level testbench for the length-prefixed frame deframer: drives bytes,
// register writes and result stalls, and gives the verdict.
// Depends on ldf_pkg, length_prefixed_frame_deframer_top and deframe_checker.
`timescale 1ns / 1ps

module tb;
  import ldf_pkg::*;

  localparam int unsigned MaxFrame      = MaxFrameDefault;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseItems    = 66;
  localparam int unsigned SettleCycles  = 5;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [CfgIndexW-1:0] CfgUnusedIndex = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_byte_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_data_byte;
  logic [9:0]           out_byte_index;
  logic                 out_last;
  logic [1:0]           out_frame_kind;
  logic                 out_checksum_ok;
  logic                 out_frame_error;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [10:0]          cfg_data;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;

  // Settings currently loaded, used to shape frames.
  logic [7:0]  cur_h1;
  logic [7:0]  cur_h2;
  logic [10:0] cur_mfl;
  bit          quiet;
  logic [7:0]  frame_q[$];

  length_prefixed_frame_deframer_top #(
    .MAX_FRAME(MaxFrame)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_frame_kind (out_frame_kind),
    .out_checksum_ok(out_checksum_ok),
    .out_frame_error(out_frame_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  deframe_checker #(
    .MAX_FRAME(MaxFrame)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_frame_kind (out_frame_kind),
    .out_checksum_ok(out_checksum_ok),
    .out_frame_error(out_frame_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each transaction, none in quiet phases.
  initial begin : result_side
    int unsigned hold;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes(input int unsigned count);
    for (int unsigned i = 0; i < count && i < frame_q.size(); i++) begin
      send_byte(frame_q[i]);
    end
  endtask

  // Header, little-endian length, kind byte, payload and XOR checksum. A length
  // beyond the build-time maximum gets no body, since it is dropped anyway.
  function automatic void build_frame(input int unsigned len, input logic [7:0] kind_byte,
                                      input bit corrupt);
    logic [7:0] csum;
    frame_q.delete();
    frame_q = {frame_q, cur_h1};
    frame_q = {frame_q, cur_h2};
    frame_q = {frame_q, 8'(len)};
    frame_q = {frame_q, 8'(len >> 8)};
    if (len + 5 <= MaxFrame) begin
      if (len > 0) begin
        frame_q = {frame_q, kind_byte};
      end
      for (int unsigned i = 1; i < len; i++) begin
        frame_q = {frame_q, 8'($urandom)};
      end
      csum = 8'h00;
      for (int i = 1; i < frame_q.size(); i++) begin
        csum = csum ^ frame_q[i];
      end
      if (corrupt) begin
        csum = csum ^ 8'($urandom_range(1, 255));
      end
      frame_q = {frame_q, csum};
    end
  endfunction

  // Stops sending and waits until every predicted result has been taken, then
  // lets header bytes that are still in the pipeline drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] h1, input logic [7:0] h2,
                               input logic [10:0] mfl);
    cfg_reg_t    reg_list [3];
    logic [10:0] val_list [3];
    reg_list = '{CFG_HEADER_FIRST, CFG_HEADER_SECOND, CFG_MAX_FRAME_LEN};
    val_list = '{{3'($urandom), h1}, {3'($urandom), h2}, mfl};
    // The last transaction goes to an index that holds no register.
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      if (i < 3) begin
        cfg_index <= reg_list[i];
        cfg_data  <= val_list[i];
      end else begin
        cfg_index <= CfgUnusedIndex;
        cfg_data  <= 11'($urandom);
      end
      @(negedge clk);
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_h1  = h1;
    cur_h2  = h2;
    cur_mfl = mfl;
  endtask

  initial begin : stimulus
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned eff;
    int unsigned top;
    int unsigned lo;
    logic [7:0]  b;
    logic [7:0]  kb;
    in_valid   = 1'b0;
    in_byte_in = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_HEADER_FIRST;
    cfg_data   = 11'd0;
    rst_n      = 1'b0;
    cur_h1     = HeaderFirstReset;
    cur_h2     = HeaderSecondReset;
    cur_mfl    = MaxFrameLenReset;
    quiet      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: noise, a broken header that is not retried, the shortest frame,
    // both special kinds, a bad checksum and an oversized length.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_h1);
    send_byte(cur_h1);
    send_byte(cur_h2);
    build_frame(0, 8'h00, 1'b0);
    send_frame_bytes(frame_q.size());
    build_frame(1, KindUpgradeByte, 1'b0);
    send_frame_bytes(frame_q.size());
    build_frame(2, KindExportByte, 1'b1);
    send_frame_bytes(frame_q.size());
    build_frame(32'hFFFF, 8'h00, 1'b0);
    send_frame_bytes(frame_q.size());

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          load_settings(HeaderFirstReset, HeaderSecondReset, 11'd1024);
          quiet = 1'b0;
        end
        1: begin load_settings(8'h00, 8'hFF, 11'd5); quiet = 1'b0; end
        2: begin load_settings(8'hFF, 8'h00, 11'd2047); quiet = 1'b1; end
        3: begin load_settings(8'($urandom), 8'($urandom), 11'd0); quiet = 1'b0; end
        4: begin
          b = 8'($urandom);
          load_settings(b, b, 11'($urandom_range(5, 64)));
          quiet = 1'b0;
        end
        5: begin
          load_settings(8'($urandom), 8'($urandom), 11'($urandom_range(5, 1024)));
          quiet = 1'b0;
        end
        6: begin load_settings(8'($urandom), 8'($urandom), 11'd4); quiet = 1'b1; end
        default: begin
          load_settings(8'($urandom), 8'($urandom), 11'($urandom_range(20, 200)));
          quiet = 1'b0;
        end
      endcase
      eff = (cur_mfl < MaxFrame) ? cur_mfl : MaxFrame;
      if (ph == 0) begin
        // One frame of the largest size reaches the top byte index.
        build_frame(eff - 5, KindExportByte, 1'b0);
        send_frame_bytes(frame_q.size());
      end
      start = bytes_sent;
      while (bytes_sent - start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 80 && eff >= 5) begin
          top = eff - 5;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(0, (top < 8) ? top : 8);
            6, 7, 8:          len = $urandom_range(0, (top < 40) ? top : 40);
            default:          len = (top <= 64) ? top : $urandom_range(0, 64);
          endcase
          case ($urandom_range(0, 2))
            0:       kb = KindUpgradeByte;
            1:       kb = KindExportByte;
            default: kb = 8'($urandom);
          endcase
          build_frame(len, kb, $urandom_range(0, 3) == 0);
          send_frame_bytes(frame_q.size());
        end else if (pick < 88) begin
          // Length just past the limit or anywhere above it; the tail after the
          // error is up to three stray bytes.
          lo = (eff >= 4) ? eff - 4 : 0;
          len = $urandom_range(0, 1) ? lo : $urandom_range(lo, 65535);
          build_frame(len, 8'($urandom), 1'b0);
          send_frame_bytes(4 + $urandom_range(0, 3));
        end else if (pick < 93) begin
          b = 8'($urandom);
          if (b == cur_h2) begin
            b = b ^ 8'h01;
          end
          send_byte(cur_h1);
          send_byte(b);
        end else if (pick < 97) begin
          build_frame($urandom_range(1, 8), 8'($urandom), 1'b0);
          send_frame_bytes($urandom_range(1, frame_q.size() - 1));
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_cfg_regs.sv
hw/rtl/ldf_in_reg.sv
hw/rtl/ldf_parser.sv
hw/rtl/ldf_out_reg.sv
hw/rtl/length_prefixed_frame_deframer_top.sv
tb/sv/deframe_checker.sv
tb/sv/tb.sv
